/* rtl/core/vttl_pkg.sv */
package vttl_pkg;

   // Command codes of an input item.
   localparam logic [1:0] CMD_LOAD      = 2'd0;
   localparam logic [1:0] CMD_NEAREST   = 2'd1;
   localparam logic [1:0] CMD_TRILINEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ORIGIN_X  = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y  = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z  = 3'd2;
   localparam logic [2:0] CSR_INV_LEN_X = 3'd3;
   localparam logic [2:0] CSR_INV_LEN_Y = 3'd4;
   localparam logic [2:0] CSR_INV_LEN_Z = 3'd5;

   // Sequencer states.
   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_LOAD  = 9'b000000100,
      ST_MUL   = 9'b000001000,
      ST_INDEX = 9'b000010000,
      ST_READ  = 9'b000100000,
      ST_CAPT  = 9'b001000000,
      ST_BLEND = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   // One linear blend stage: (a*(4096-f) + b*f + 2048) >> 12, rounding half up.
   function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
                                         input logic [11:0] f);
      logic [36:0] s;
      s = 37'(a) * 37'(13'd4096 - 13'(f)) + 37'(b) * 37'(f) + 37'd2048;
      return s[35:12];
   endfunction

endpackage

/* rtl/core/voxel_table_trilinear_lookup_unit.sv */
// Channel   Direction  Handshake        Payload
// req_*     in         valid / stall    cmd, vox_addr, channel, entry_value, pos_x/y/z
// rsp_*     out        valid / stall    visibility, in_grid, interpolated
// csr_*     in         valid / ready    index, data (ready is always high)
//
// Lookups are paced by the single-port table: each of the eight trilinear corners
// passes through a read and a capture state, and the seven blends share one blend
// unit.
// After reset a clearing pass writes zero to all GRID_X*GRID_Y*GRID_Z*CHANNELS
// entries, one a cycle, and no item is accepted until it ends.
// A waiting result holds the sequencer only until the output register frees.
module voxel_table_trilinear_lookup_unit #(
   parameter int GRID_X   = 16,
   parameter int GRID_Y   = 16,
   parameter int GRID_Z   = 32,
   parameter int CHANNELS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [12:0]        req_vox_addr,
   input  logic [4:0]         req_channel,
   input  logic [23:0]        req_entry_value,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [23:0]        rsp_visibility,
   output logic               rsp_in_grid,
   output logic               rsp_interpolated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int NVOX  = GRID_X * GRID_Y * GRID_Z;
   localparam int DEPTH = NVOX * CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int STEP_X = CHANNELS;
   localparam int STEP_Y = GRID_X * CHANNELS;
   localparam int STEP_Z = GRID_X * GRID_Y * CHANNELS;

   // Configuration registers.
   logic signed [15:0] org_x_ff, org_y_ff, org_z_ff;
   logic [15:0]        inv_x_ff, inv_y_ff, inv_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= -16'sd990;
         org_y_ff <= -16'sd3081;
         org_z_ff <= -16'sd1480;
         inv_x_ff <= 16'd12826;
         inv_y_ff <= 16'd12826;
         inv_z_ff <= 16'd21456;
      end else if (csr_valid) begin
         case (csr_index)
            vttl_pkg::CSR_ORIGIN_X:  org_x_ff <= csr_data;
            vttl_pkg::CSR_ORIGIN_Y:  org_y_ff <= csr_data;
            vttl_pkg::CSR_ORIGIN_Z:  org_z_ff <= csr_data;
            vttl_pkg::CSR_INV_LEN_X: inv_x_ff <= csr_data;
            vttl_pkg::CSR_INV_LEN_Y: inv_y_ff <= csr_data;
            vttl_pkg::CSR_INV_LEN_Z: inv_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Control and item registers.
   vttl_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_ff;
   logic [1:0]          cmd_ff;
   logic [12:0]         vid_ff;
   logic [4:0]          ch_ff;
   logic [23:0]         val_ff;
   logic signed [15:0]  px_ff, py_ff, pz_ff;
   logic signed [33:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic [AW-1:0]       base_ff;
   logic                tri_ff, inside_ff, rd_ok_ff;
   logic [11:0]         fx_ff, fy_ff, fz_ff;
   logic [2:0]          cnt_ff;
   logic [23:0]         w_ff [8];
   logic [23:0]         mem_q;
   logic                rsp_valid_ff;
   logic [23:0]         rsp_vis_ff;
   logic                rsp_grid_ff, rsp_interp_ff;

   logic [23:0] mem [DEPTH];
   logic        accept;
   logic        out_free;

   assign req_stall = (state_ff != vttl_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Coordinate mapping, floor for trilinear and truncation for nearest.
   logic signed [13:0] fl_x, fl_y, fl_z, tr_x, tr_y, tr_z;
   logic               ok_tri, ok_near, ch_ok;
   logic [AW-1:0]      base_tri, base_near, rd_addr;

   always_comb begin
      fl_x = 14'(prod_x_ff >>> 20);
      fl_y = 14'(prod_y_ff >>> 20);
      fl_z = 14'(prod_z_ff >>> 20);
      tr_x = 14'((prod_x_ff + (prod_x_ff[33] ? 34'sd1048575 : 34'sd0)) >>> 20);
      tr_y = 14'((prod_y_ff + (prod_y_ff[33] ? 34'sd1048575 : 34'sd0)) >>> 20);
      tr_z = 14'((prod_z_ff + (prod_z_ff[33] ? 34'sd1048575 : 34'sd0)) >>> 20);
      ok_tri = !fl_x[13] && (fl_x <= 14'(GRID_X - 2))
            && !fl_y[13] && (fl_y <= 14'(GRID_Y - 2))
            && !fl_z[13] && (fl_z <= 14'(GRID_Z - 2));
      ok_near = !tr_x[13] && (tr_x < 14'(GRID_X))
             && !tr_y[13] && (tr_y < 14'(GRID_Y))
             && !tr_z[13] && (tr_z < 14'(GRID_Z));
      ch_ok = (7'(ch_ff) < 7'(CHANNELS));
      base_tri  = AW'(fl_x) * AW'(STEP_X) + AW'(fl_y) * AW'(STEP_Y)
                + AW'(fl_z) * AW'(STEP_Z) + AW'(ch_ff);
      base_near = AW'(tr_x) * AW'(STEP_X) + AW'(tr_y) * AW'(STEP_Y)
                + AW'(tr_z) * AW'(STEP_Z) + AW'(ch_ff);
      rd_addr = base_ff + (cnt_ff[0] ? AW'(STEP_X) : '0)
              + (cnt_ff[1] ? AW'(STEP_Y) : '0) + (cnt_ff[2] ? AW'(STEP_Z) : '0);
   end

   // Blend step selection: four x blends, two y blends, one z blend.
   logic [2:0]  bj;
   logic [11:0] bf;
   logic [23:0] bres;

   always_comb begin
      if (cnt_ff < 3'd4) begin
         bj = cnt_ff;
         bf = fx_ff;
      end else if (cnt_ff < 3'd6) begin
         bj = cnt_ff - 3'd4;
         bf = fy_ff;
      end else begin
         bj = 3'd0;
         bf = fz_ff;
      end
      bres = vttl_pkg::blend(w_ff[3'(bj << 1)], w_ff[3'((bj << 1) | 3'd1)], bf);
   end

   // Table memory: clearing pass, loads and one registered read.
   always_ff @(posedge clock) begin
      if (state_ff == vttl_pkg::ST_CLEAR) begin
         mem[clr_ff] <= '0;
      end else if (state_ff == vttl_pkg::ST_LOAD && (32'(vid_ff) < 32'(NVOX)) && ch_ok) begin
         mem[AW'(vid_ff) * AW'(CHANNELS) + AW'(ch_ff)] <= val_ff;
      end
      mem_q <= mem[rd_addr];
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vttl_pkg::ST_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = vttl_pkg::ST_IDLE;
         vttl_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == vttl_pkg::CMD_LOAD) state_in = vttl_pkg::ST_LOAD;
               else if (req_cmd == vttl_pkg::CMD_NEAREST
                        || req_cmd == vttl_pkg::CMD_TRILINEAR) state_in = vttl_pkg::ST_MUL;
            end
         end
         vttl_pkg::ST_LOAD:  state_in = vttl_pkg::ST_IDLE;
         vttl_pkg::ST_MUL:   state_in = vttl_pkg::ST_INDEX;
         vttl_pkg::ST_INDEX: state_in = vttl_pkg::ST_READ;
         vttl_pkg::ST_READ:  state_in = vttl_pkg::ST_CAPT;
         vttl_pkg::ST_CAPT: begin
            if (!tri_ff) state_in = vttl_pkg::ST_OUT;
            else if (cnt_ff == 3'd7) state_in = vttl_pkg::ST_BLEND;
            else state_in = vttl_pkg::ST_READ;
         end
         vttl_pkg::ST_BLEND: if (cnt_ff == 3'd6) state_in = vttl_pkg::ST_OUT;
         vttl_pkg::ST_OUT:   if (out_free) state_in = vttl_pkg::ST_IDLE;
         default:            state_in = vttl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vttl_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == vttl_pkg::ST_CLEAR) clr_ff <= clr_ff + AW'(1);
      end
   end

   // Item capture, grid products, address generation, corner capture and blends.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         vid_ff <= req_vox_addr;
         ch_ff  <= req_channel;
         val_ff <= req_entry_value;
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         pz_ff  <= req_pos_z;
      end
      if (state_ff == vttl_pkg::ST_MUL) begin
         prod_x_ff <= 34'(17'(px_ff) - 17'(org_x_ff)) * $signed({18'd0, inv_x_ff});
         prod_y_ff <= 34'(17'(py_ff) - 17'(org_y_ff)) * $signed({18'd0, inv_y_ff});
         prod_z_ff <= 34'(17'(pz_ff) - 17'(org_z_ff)) * $signed({18'd0, inv_z_ff});
      end
      if (state_ff == vttl_pkg::ST_INDEX) begin
         tri_ff    <= (cmd_ff == vttl_pkg::CMD_TRILINEAR) && ok_tri;
         inside_ff <= ((cmd_ff == vttl_pkg::CMD_TRILINEAR) && ok_tri) || ok_near;
         rd_ok_ff  <= ch_ok && (((cmd_ff == vttl_pkg::CMD_TRILINEAR) && ok_tri) || ok_near);
         base_ff   <= ((cmd_ff == vttl_pkg::CMD_TRILINEAR) && ok_tri) ? base_tri : base_near;
         fx_ff     <= prod_x_ff[19:8];
         fy_ff     <= prod_y_ff[19:8];
         fz_ff     <= prod_z_ff[19:8];
         cnt_ff    <= '0;
      end
      if (state_ff == vttl_pkg::ST_CAPT) begin
         w_ff[cnt_ff] <= rd_ok_ff ? mem_q : 24'd0;
         cnt_ff       <= (cnt_ff == 3'd7) ? 3'd0 : cnt_ff + 3'd1;
      end
      if (state_ff == vttl_pkg::ST_BLEND) begin
         w_ff[bj] <= bres;
         cnt_ff   <= cnt_ff + 3'd1;
      end
   end

   // Output register, free to load while the sequencer moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == vttl_pkg::ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == vttl_pkg::ST_OUT && out_free) begin
         rsp_vis_ff    <= w_ff[0];
         rsp_grid_ff   <= inside_ff;
         rsp_interp_ff <= tri_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_visibility   = rsp_vis_ff;
   assign rsp_in_grid      = rsp_grid_ff;
   assign rsp_interpolated = rsp_interp_ff;

endmodule
